/* hdl/open_addressing_hash_set_unit_assert.svh */
// Assertion macros for the open-addressing hash set unit.
`ifndef OPEN_ADDRESSING_HASH_SET_UNIT_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_SET_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OAHS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OAHS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/oahs_pkg.sv */
// Shared constants, types and helpers for the open-addressing hash set unit.
package oahs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_BITS    = 64;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = ADDR_BITS + 1;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 64;
    localparam int HASH_W   = 10;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int OCC_W    = 10;
    localparam int LIMIT_W  = 10;

    localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = LIMIT_W'(716);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [OCC_W-1:0]     count_t;
    typedef logic [LIMIT_W-1:0]   limit_t;
    typedef logic [HASH_W-1:0]    hash_t;
    typedef logic [KEY_BITS-1:0]  tkey_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_INSERT_NEW = 2'd1,
        OP_FIND       = 2'd2,
        OP_CLEAR      = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    function automatic addr_t home_slot(hash_t h);
        return addr_t'(h);
    endfunction

    function automatic slot_t to_slot(addr_t a);
        return slot_t'(a);
    endfunction

endpackage

/* hdl/open_addressing_hash_set_unit.sv */
// Top level of the open-addressing hash set unit with triangular probing.
//
// Usage: items enter on the s_ valid/ready channel (opcode, key, key_hash);
// one result per item leaves on the m_ valid/ready channel (status, slot,
// occupied). The fill limit is written on the cfg_ channel, which is always
// ready; a new limit takes effect at the next clear.
// Insert and find walk the probe sequence with one key memory read per cycle,
// one read of the single key memory per probe, 1 to 1024 probes per item;
// the next item is accepted only once the last one is done.
// The result is registered.
// Clear sweeps all 1024 slots, one per cycle.
// After reset the same sweep runs before s_ready rises.
// A stalled receiver holds the result register; the next item is still
// accepted and worked on, and waits for the held result to be taken before
// the one after it is accepted.
module open_addressing_hash_set_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [oahs_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [oahs_pkg::OPCODE_W-1:0] s_opcode,
    input  logic [oahs_pkg::KEY_W-1:0]    s_key,
    input  logic [oahs_pkg::HASH_W-1:0]   s_key_hash,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [oahs_pkg::STATUS_W-1:0] m_status,
    output logic [oahs_pkg::SLOT_W-1:0]   m_slot,
    output logic [oahs_pkg::OCC_W-1:0]    m_occupied
);

    import oahs_pkg::*;

    `include "open_addressing_hash_set_unit_assert.svh"

    localparam int RAM_W = KEY_BITS + 1;

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_PROBE = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    cnt_reg, cnt_next;
    addr_t   pos_reg, pos_next;
    opcode_t op_reg, op_next;
    tkey_t   key_reg, key_next;
    limit_t  fill_limit_reg, fill_limit_next;
    limit_t  free_left_reg, free_left_next;
    count_t  count_reg, count_next;
    status_t res_status_reg, res_status_next;
    slot_t   res_slot_reg, res_slot_next;
    logic    m_valid_reg, m_valid_next;
    status_t out_status_reg, out_status_next;
    slot_t   out_slot_reg, out_slot_next;
    count_t  out_occ_reg, out_occ_next;

    logic             ram_we;
    addr_t            ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    addr_t            ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    logic rd_live;
    logic rd_match;
    cnt_t cnt_inc;

    oahs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_live  = ram_rdata[KEY_BITS];
    assign rd_match = (ram_rdata[KEY_BITS-1:0] == key_reg);
    assign cnt_inc  = cnt_reg + 1'b1;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = out_status_reg;
    assign m_slot     = out_slot_reg;
    assign m_occupied = out_occ_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        fill_limit_next = fill_limit_reg;
        free_left_next  = free_left_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = {1'b1, key_reg};
        ram_raddr       = pos_reg;

        if (cfg_valid) begin
            fill_limit_next = cfg_data;
        end

        case (state_reg)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_BITS-1:0];
                ram_wdata = '0;
                cnt_next  = cnt_inc;
                if (cnt_reg[ADDR_BITS-1:0] == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = home_slot(s_key_hash);
                if (s_valid) begin
                    op_next  = opcode_t'(s_opcode);
                    key_next = s_key[KEY_BITS-1:0];
                    pos_next = home_slot(s_key_hash);
                    cnt_next = '0;
                    if (opcode_t'(s_opcode) == OP_CLEAR) begin
                        state_next = S_CLEAR;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (!rd_live) begin
                    res_slot_next = '0;
                    if (op_reg == OP_FIND) begin
                        res_status_next = ST_NOT_FOUND;
                    end else if (free_left_reg == '0) begin
                        res_status_next = ST_FULL;
                    end else begin
                        ram_we          = 1'b1;
                        free_left_next  = free_left_reg - 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_INSERTED;
                        res_slot_next   = to_slot(pos_reg);
                    end
                    state_next = S_DONE;
                end else if (op_reg != OP_INSERT_NEW && rd_match) begin
                    res_status_next = (op_reg == OP_FIND) ? ST_FOUND : ST_DUPLICATE;
                    res_slot_next   = to_slot(pos_reg);
                    state_next      = S_DONE;
                end else if (cnt_inc == CNT_BITS'(TABLE_DEPTH)) begin
                    res_status_next = (op_reg == OP_FIND) ? ST_NOT_FOUND : ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end else begin
                    cnt_next  = cnt_inc;
                    pos_next  = pos_reg + cnt_inc[ADDR_BITS-1:0];
                    ram_raddr = pos_reg + cnt_inc[ADDR_BITS-1:0];
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_BITS-1:0];
                ram_wdata = '0;
                cnt_next  = cnt_inc;
                if (cnt_reg[ADDR_BITS-1:0] == '1) begin
                    free_left_next  = fill_limit_reg;
                    count_next      = '0;
                    res_status_next = ST_CLEARED;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_occ_next    = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            fill_limit_reg <= FILL_LIMIT_RESET;
            free_left_reg  <= FILL_LIMIT_RESET;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fill_limit_reg <= fill_limit_next;
            free_left_reg  <= free_left_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_occ_reg    <= out_occ_next;
    end

    `OAHS_ASSERT_NOW(a_we_state, aclk, aresetn, ram_we,
        (state_reg == S_PROBE || state_reg == S_CLEAR || state_reg == S_INIT),
        "key memory written outside probe or sweep")

    `OAHS_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        (state_reg == S_PROBE || state_reg == S_CLEAR),
        "accepted transaction did not start work")

    `OAHS_ASSERT_NEXT(a_insert_counts, aclk, aresetn, ram_we && state_reg == S_PROBE,
        (count_reg == count_t'($past(count_reg) + 1'b1)),
        "insert did not bump the entry count")

    `OAHS_ASSERT_NOW(a_slot_zero, aclk, aresetn,
        m_valid && (m_status == ST_NOT_FOUND || m_status == ST_FULL ||
        m_status == ST_CLEARED),
        (m_slot == '0), "slot not zero for a miss, full or clear")

endmodule

/* hdl/oahs_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module oahs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* dv/tb_open_addressing_hash_set_unit.sv */
// Testbench for the hash set unit: directed and random set operations checked against a mirror table.
module tb_open_addressing_hash_set_unit;
    import oahs_pkg::*;

    // Slowest legal items are a clear and a full probe walk; this covers every item at that cost plus stalls.
    localparam int CYCLE_LIMIT     = 10_000_000;
    localparam int POOL_SIZE       = 48;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 188;
    localparam limit_t PHASE_LIMIT [NUM_PHASES] =
        '{10'd1023, 10'd5, 10'd716, 10'd60, 10'd1, 10'd250, 10'd20, 10'd400};
    localparam int PHASE_SPREAD [NUM_PHASES] = '{1023, 15, 63, 7, 1023, 31, 3, 255};

    typedef struct {
        opcode_t op;
        tkey_t   key;
        hash_t   hash;
    } set_op_t;

    typedef struct {
        status_t status;
        slot_t   slot;
        count_t  occupied;
    } set_outcome_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    limit_t              cfg_data   = '0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode   = '0;
    tkey_t               s_key      = '0;
    hash_t               s_key_hash = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [STATUS_W-1:0] m_status;
    slot_t               m_slot;
    count_t              m_occupied;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit rx_hold        = 1'b0;
    int err_count      = 0;
    int cycle_count    = 0;

    set_op_t      op_q[$];
    set_outcome_t outcome_q[$];
    set_op_t      offered;

    bit     mirror_valid [TABLE_DEPTH];
    tkey_t  mirror_key [TABLE_DEPTH];
    int     mirror_free;
    int     mirror_count;
    limit_t mirror_limit = FILL_LIMIT_RESET;

    tkey_t pool_key [POOL_SIZE];
    hash_t pool_hash [POOL_SIZE];

    open_addressing_hash_set_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_key      (s_key),
        .s_key_hash (s_key_hash),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_slot     (m_slot),
        .m_occupied (m_occupied)
    );

    always #10 aclk = ~aclk;

    function automatic void mirror_clear();
        foreach (mirror_valid[i]) mirror_valid[i] = 1'b0;
        mirror_free  = int'(mirror_limit);
        mirror_count = 0;
    endfunction

    // Triangular probe walk; returns 0 once every probe is used up.
    function automatic bit mirror_probe(input tkey_t k, input hash_t h, input bit cmp,
                                        output int where, output bit hit);
        int pos;
        pos   = int'(h) & (TABLE_DEPTH - 1);
        where = 0;
        hit   = 1'b0;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            if (!mirror_valid[pos]) begin
                where = pos;
                return 1'b1;
            end
            if (cmp && mirror_key[pos] == k) begin
                where = pos;
                hit   = 1'b1;
                return 1'b1;
            end
            pos = (pos + n + 1) & (TABLE_DEPTH - 1);
        end
        return 1'b0;
    endfunction

    function automatic set_outcome_t set_outcome(input set_op_t t);
        set_outcome_t r;
        int           where;
        bit           hit;
        bit           ok;
        r.status = ST_CLEARED;
        r.slot   = '0;
        case (t.op)
            OP_CLEAR: begin
                mirror_clear();
            end
            OP_FIND: begin
                ok = mirror_probe(t.key, t.hash, 1'b1, where, hit);
                if (ok && hit) begin
                    r.status = ST_FOUND;
                    r.slot   = slot_t'(where);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                ok = mirror_probe(t.key, t.hash, t.op == OP_INSERT, where, hit);
                if (ok && hit) begin
                    r.status = ST_DUPLICATE;
                    r.slot   = slot_t'(where);
                end else if (!ok || mirror_free == 0) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_valid[where] = 1'b1;
                    mirror_key[where]   = t.key;
                    mirror_free--;
                    mirror_count++;
                    r.status = ST_INSERTED;
                    r.slot   = slot_t'(where);
                end
            end
        endcase
        r.occupied = count_t'(mirror_count);
        return r;
    endfunction

    function automatic void flag_error(input string what);
        err_count++;
        if (err_count <= 10) $display("mismatch: %s", what);
    endfunction

    task automatic send(input opcode_t op, input tkey_t k, input hash_t h);
        set_op_t t;
        t.op   = op;
        t.key  = k;
        t.hash = h;
        op_q.push_back(t);
    endtask

    task automatic wait_drained();
        while (op_q.size() != 0 || s_valid || outcome_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_fill_limit(input limit_t v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        mirror_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_pool(input int spread);
        hash_t base;
        base = hash_t'($urandom);
        foreach (pool_key[i]) begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = base + hash_t'($urandom_range(spread));
        end
        pool_key[0] = '0;
        pool_key[1] = '1;
    endtask

    // Mostly consistent key/hash pairs so finds and duplicates hit; some noise.
    task automatic send_random();
        int r;
        int p;
        r = $urandom_range(99);
        p = $urandom_range(POOL_SIZE - 1);
        if (r < 3)
            send(OP_CLEAR, {$urandom, $urandom}, hash_t'($urandom));
        else if (r < 43)
            send(OP_INSERT, pool_key[p], pool_hash[p]);
        else if (r < 55)
            send(OP_INSERT_NEW, pool_key[p], pool_hash[p]);
        else if (r < 88)
            send(OP_FIND, pool_key[p], pool_hash[p]);
        else
            send(opcode_t'($urandom_range(2)), {$urandom, $urandom}, hash_t'($urandom));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) outcome_q.push_back(set_outcome(offered));
            if (!s_valid || s_ready) begin
                if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = op_q.pop_front();
                    s_valid    <= 1'b1;
                    s_opcode   <= offered.op;
                    s_key      <= offered.key;
                    s_key_hash <= offered.hash;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        set_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    flag_error($sformatf("unexpected transaction status %0d slot %0d occ %0d",
                                         m_status, m_slot, m_occupied));
                end else begin
                    want = outcome_q.pop_front();
                    if (m_status !== want.status || m_slot !== want.slot ||
                        m_occupied !== want.occupied)
                        flag_error($sformatf(
                            "status %0d/%0d slot %0d/%0d occ %0d/%0d (expected/actual)",
                            want.status, m_status, want.slot, m_slot,
                            want.occupied, m_occupied));
                end
            end
            m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        limit_t lim;
        int     mode;
        mirror_clear();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        // collisions, wraparound, duplicates, insert known new over an existing key
        send(OP_FIND,       64'h0, 10'd0);
        send(OP_INSERT,     64'h0, 10'd0);
        send(OP_INSERT,     64'h0, 10'd0);
        send(OP_INSERT,     '1, 10'd0);
        send(OP_INSERT,     64'h5, 10'd0);
        send(OP_INSERT,     64'h6, 10'd1023);
        send(OP_INSERT,     64'h7, 10'd1023);
        send(OP_FIND,       '1, 10'd0);
        send(OP_FIND,       64'h5, 10'd1023);
        send(OP_INSERT_NEW, 64'h0, 10'd0);
        send(OP_FIND,       64'h0, 10'd0);
        send(OP_FIND,       64'h5555_5555_5555_5555, 10'h2AA);
        wait_drained();

        // new limit only applies after a clear; then run out of free entries
        write_fill_limit(10'd2);
        send(OP_INSERT,     64'hAAAA_AAAA_AAAA_AAAA, 10'h155);
        send(OP_CLEAR,      64'h0, 10'd0);
        send(OP_INSERT,     64'h11, 10'd5);
        send(OP_INSERT,     64'h22, 10'd5);
        send(OP_INSERT,     64'h33, 10'd5);
        send(OP_INSERT,     64'h11, 10'd5);
        send(OP_INSERT_NEW, 64'h11, 10'd5);
        send(OP_FIND,       64'h22, 10'd5);
        wait_drained();

        write_fill_limit(10'd0);
        send(OP_CLEAR,      '1, 10'd1023);
        send(OP_INSERT,     64'h44, 10'd9);
        send(OP_INSERT_NEW, 64'h44, 10'd9);
        send(OP_FIND,       64'h44, 10'd9);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            lim = (ph == NUM_PHASES - 1) ? limit_t'($urandom_range(1, 1023)) : PHASE_LIMIT[ph];
            write_fill_limit(lim);
            mode = ph % 4;
            send_idle_pct  <= (mode == 1) ? 88 : (mode == 3) ? 29 : 0;
            recv_stall_pct <= (mode == 2) ? 88 : (mode == 3) ? 29 : 0;
            fill_pool(PHASE_SPREAD[ph]);
            send(OP_CLEAR, {$urandom, $urandom}, hash_t'($urandom));
            for (int i = 0; i < ITEMS_PER_PHASE / 2; i++) send_random();
            if (ph == 0) begin
                rx_hold <= 1'b1;
                repeat (600) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            if (ph == 5) wait_drained();
            for (int i = ITEMS_PER_PHASE / 2; i < ITEMS_PER_PHASE; i++) send_random();
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/oahs_pkg.sv
hdl/oahs_ram.sv
hdl/open_addressing_hash_set_unit.sv
dv/tb_open_addressing_hash_set_unit.sv
